// ----- rtl/core/pur_pkg.sv -----
// Shared types and constants for the picture processor scroll register unit.
package pur_pkg;

	typedef enum logic [1:0] {
		REQ_DOT   = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2
	} req_kind_t;

	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	localparam logic [8:0] DOT_LAST       = 9'd340;
	localparam logic [8:0] PRE_LINE       = 9'd261;
	localparam logic [8:0] VISIBLE_LINES  = 9'd240;
	localparam logic [8:0] VBLANK_LINE    = 9'd241;
	localparam logic [8:0] FETCH_LAST     = 9'd256;
	localparam logic [8:0] INC_Y_DOT      = 9'd256;
	localparam logic [8:0] HCOPY_DOT      = 9'd257;
	localparam logic [8:0] VCOPY_FIRST    = 9'd280;
	localparam logic [8:0] VCOPY_LAST     = 9'd304;
	localparam logic [8:0] PREFETCH_FIRST = 9'd321;
	localparam logic [8:0] PREFETCH_LAST  = 9'd336;
	localparam logic [8:0] FLAG_DOT       = 9'd1;

	localparam logic [4:0]  COARSE_LAST   = 5'h1F;
	localparam logic [4:0]  COARSE_Y_ROWS = 5'h1D;
	localparam logic [2:0]  FINE_MAX      = 3'h7;
	localparam logic [5:0]  PALETTE_PAGE  = 6'h3F;
	localparam logic [14:0] STEP_DOWN     = 15'h0020;
	localparam logic [14:0] STEP_ACROSS   = 15'h0001;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] vram_read_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [14:0] vram_addr;
		logic        vram_write;
		logic [7:0]  vram_write_data;
		logic        nmi_pulse;
		logic [2:0]  fine_x_scroll;
		logic [8:0]  dot_index;
		logic [8:0]  scanline_index;
	} result_t;

endpackage

// ----- rtl/core/pur_intf.sv -----
// Valid/ready channel interfaces for request items and result items.
interface pur_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] vram_read_data;

	modport source (output valid, req_type, reg_index, write_data, vram_read_data,
		input ready);
	modport sink (input valid, req_type, reg_index, write_data, vram_read_data,
		output ready);
endinterface

interface pur_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [14:0] vram_addr;
	logic        vram_write;
	logic [7:0]  vram_write_data;
	logic        nmi_pulse;
	logic [2:0]  fine_x_scroll;
	logic [8:0]  dot_index;
	logic [8:0]  scanline_index;

	modport source (output valid, read_data, vram_addr, vram_write, vram_write_data,
		nmi_pulse, fine_x_scroll, dot_index, scanline_index, input ready);
	modport sink (input valid, read_data, vram_addr, vram_write, vram_write_data,
		nmi_pulse, fine_x_scroll, dot_index, scanline_index, output ready);
endinterface

// ----- rtl/core/ppu_scroll_register_unit.sv -----
// Top level: input register, register/scroll engine and result register.
// A result is offered from the result register once its item has passed the input register and the engine.
// Throughput: one item per cycle while the result channel is not stalled; the engine computes all
// state updates between the input register and the result register.
// A stalled result holds in the result register while one more item waits.
// Reset clears all engine state, both valid flags, and the dot and line counters.
module ppu_scroll_register_unit (
	input logic      clk,
	input logic      arst_n,
	pur_req_if.sink  req,
	pur_rsp_if.source rsp
);
	import pur_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    advance;
	logic    step;

	assign advance   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= '{req_type: req.req_type, reg_index: req.reg_index,
				write_data: req.write_data, vram_read_data: req.vram_read_data};
		end
	end

	pur_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.read_data       = result_s2.read_data;
	assign rsp.vram_addr       = result_s2.vram_addr;
	assign rsp.vram_write      = result_s2.vram_write;
	assign rsp.vram_write_data = result_s2.vram_write_data;
	assign rsp.nmi_pulse       = result_s2.nmi_pulse;
	assign rsp.fine_x_scroll   = result_s2.fine_x_scroll;
	assign rsp.dot_index       = result_s2.dot_index;
	assign rsp.scanline_index  = result_s2.scanline_index;

endmodule

// ----- rtl/core/pur_engine.sv -----
// Register file, scroll address logic and dot/line timing; one item per step.
module pur_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pur_pkg::item_t   item,
	output pur_pkg::result_t result
);
	import pur_pkg::*;

	logic [14:0] temp_q, temp_d;
	logic [14:0] cur_q, cur_d;
	logic [2:0]  fine_x_q, fine_x_d;
	logic        toggle_q, toggle_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  mask_q, mask_d;
	logic [7:0]  status_q, status_d;
	logic [7:0]  rbuf_q, rbuf_d;
	logic [7:0]  oam_val_q, oam_val_d;
	logic [8:0]  dot_q, dot_d;
	logic [8:0]  line_q, line_d;

	logic        bg_on;
	logic        render_line;
	logic [4:0]  row_y;
	logic [7:0]  rdata;
	logic        nmi;
	logic        vwrite;
	logic [7:0]  vwdata;
	logic [14:0] bump;

	always_comb begin
		temp_d     = temp_q;
		cur_d      = cur_q;
		fine_x_d   = fine_x_q;
		toggle_d   = toggle_q;
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		status_d   = status_q;
		rbuf_d     = rbuf_q;
		oam_val_d  = oam_val_q;
		dot_d      = dot_q;
		line_d     = line_q;
		rdata      = '0;
		nmi        = 1'b0;
		vwrite     = 1'b0;
		vwdata     = '0;
		row_y      = cur_q[9:5];
		bg_on      = mask_q[3];
		render_line = (line_q < VISIBLE_LINES) || (line_q == PRE_LINE);
		bump       = ctrl_q[2] ? STEP_DOWN : STEP_ACROSS;

		case (item.req_type)
			REQ_DOT: begin
				if (line_q == PRE_LINE && dot_q == FLAG_DOT) begin
					status_d = '0;
				end
				if (render_line) begin
					if (bg_on && dot_q[2:0] == 3'd0 &&
						((dot_q != 9'd0 && dot_q <= FETCH_LAST) ||
						(dot_q >= PREFETCH_FIRST && dot_q <= PREFETCH_LAST))) begin
						if (cur_d[4:0] == COARSE_LAST) begin
							cur_d[4:0] = 5'd0;
							cur_d[10]  = ~cur_d[10];
						end else begin
							cur_d[4:0] = cur_d[4:0] + 5'd1;
						end
					end
					if (bg_on && dot_q == INC_Y_DOT) begin
						if (cur_d[14:12] != FINE_MAX) begin
							cur_d[14:12] = cur_d[14:12] + 3'd1;
						end else begin
							cur_d[14:12] = 3'd0;
							row_y = cur_d[9:5];
							if (row_y == COARSE_Y_ROWS) begin
								row_y     = 5'd0;
								cur_d[11] = ~cur_d[11];
							end else if (row_y == COARSE_LAST) begin
								row_y = 5'd0;
							end else begin
								row_y = row_y + 5'd1;
							end
							cur_d[9:5] = row_y;
						end
					end
					if (bg_on && dot_q == HCOPY_DOT) begin
						cur_d[4:0] = temp_q[4:0];
						cur_d[10]  = temp_q[10];
					end
				end
				if (bg_on && line_q == PRE_LINE && dot_q >= VCOPY_FIRST &&
					dot_q <= VCOPY_LAST) begin
					cur_d[9:5]   = temp_q[9:5];
					cur_d[14:11] = temp_q[14:11];
				end
				if (line_q == VBLANK_LINE && dot_q == FLAG_DOT) begin
					status_d[7] = 1'b1;
					nmi         = ctrl_q[7];
				end
				if (dot_q >= DOT_LAST) begin
					dot_d  = '0;
					line_d = (line_q >= PRE_LINE) ? 9'd0 : line_q + 9'd1;
				end else begin
					dot_d = dot_q + 9'd1;
				end
			end
			REQ_WRITE: begin
				case (item.reg_index)
					REG_CTRL: begin
						ctrl_d        = item.write_data;
						temp_d[11:10] = item.write_data[1:0];
					end
					REG_MASK: mask_d = item.write_data;
					REG_OAM_DATA: oam_val_d = item.write_data;
					REG_SCROLL: begin
						if (!toggle_q) begin
							temp_d[4:0] = item.write_data[7:3];
							fine_x_d    = item.write_data[2:0];
							toggle_d    = 1'b1;
						end else begin
							temp_d[9:5]   = item.write_data[7:3];
							temp_d[14:12] = item.write_data[2:0];
							toggle_d      = 1'b0;
						end
					end
					REG_ADDR: begin
						if (!toggle_q) begin
							temp_d[14:8] = {1'b0, item.write_data[5:0]};
							toggle_d     = 1'b1;
						end else begin
							temp_d[7:0] = item.write_data;
							cur_d       = {temp_q[14:8], item.write_data};
							toggle_d    = 1'b0;
						end
					end
					REG_DATA: begin
						vwrite = 1'b1;
						vwdata = item.write_data;
						cur_d  = cur_q + bump;
					end
					default: begin
					end
				endcase
			end
			REQ_READ: begin
				case (item.reg_index)
					REG_STATUS: begin
						rdata       = status_q;
						status_d[7] = 1'b0;
						toggle_d    = 1'b0;
					end
					REG_OAM_DATA: rdata = oam_val_q;
					REG_DATA: begin
						rdata  = (cur_q[13:8] == PALETTE_PAGE) ? item.vram_read_data : rbuf_q;
						rbuf_d = item.vram_read_data;
						cur_d  = cur_q + bump;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q     <= '0;
			cur_q      <= '0;
			fine_x_q   <= '0;
			toggle_q   <= 1'b0;
			ctrl_q     <= '0;
			mask_q     <= '0;
			status_q   <= '0;
			rbuf_q     <= '0;
			oam_val_q  <= '0;
			dot_q      <= '0;
			line_q     <= '0;
		end else if (step) begin
			temp_q     <= temp_d;
			cur_q      <= cur_d;
			fine_x_q   <= fine_x_d;
			toggle_q   <= toggle_d;
			ctrl_q     <= ctrl_d;
			mask_q     <= mask_d;
			status_q   <= status_d;
			rbuf_q     <= rbuf_d;
			oam_val_q  <= oam_val_d;
			dot_q      <= dot_d;
			line_q     <= line_d;
		end
	end

	assign result.read_data       = rdata;
	assign result.vram_addr       = cur_q;
	assign result.vram_write      = vwrite;
	assign result.vram_write_data = vwdata;
	assign result.nmi_pulse       = nmi;
	assign result.fine_x_scroll   = fine_x_d;
	assign result.dot_index       = dot_q;
	assign result.scanline_index  = line_q;

endmodule

// ----- rtl/core/pur_checker.sv -----
// Port-level checks on the result channel of the scroll register unit.
module pur_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] read_data,
	input logic       vram_write,
	input logic       nmi_pulse,
	input logic [8:0] dot_index,
	input logic [8:0] scanline_index
);
	import pur_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(dot_index) &&
		$stable(scanline_index) && $stable(read_data))
		else $error("stalled result changed");

	a_nmi_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && nmi_pulse |-> dot_index == FLAG_DOT && scanline_index == VBLANK_LINE)
		else $error("nmi outside vblank start");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> dot_index <= DOT_LAST && scanline_index <= PRE_LINE)
		else $error("timing counter out of range");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && vram_write |-> read_data == 8'd0 && !nmi_pulse)
		else $error("write item carries read data or nmi");

endmodule

bind ppu_scroll_register_unit pur_checker u_pur_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_data      (rsp.read_data),
	.vram_write     (rsp.vram_write),
	.nmi_pulse      (rsp.nmi_pulse),
	.dot_index      (rsp.dot_index),
	.scanline_index (rsp.scanline_index)
);
